// ===== rtl/core/asmc_pkg.sv =====
// asmc_pkg: shared types and constants for the median state set cost block
// used by asmc_seq, asmc_datapath and ambiguous_state_median_cost_top
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package asmc_pkg;

   localparam int SET_BITS   = 8;
   localparam int IDX_BITS   = 3;
   localparam int ALPHA_BITS = 4;
   localparam int TOTAL_BITS = 17;

   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 4'd5;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX   = 17'h1FFFF;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DRAIN_A,
      SEQ_DRAIN_B,
      SEQ_DONE
   } asmc_state_type;

   // one table read issued by the sequencer
   typedef struct packed {
      logic                valid;
      logic                direct;
      logic                first_p;
      logic                last_p;
      logic                first_k;
      logic [IDX_BITS-1:0] p;
      logic [IDX_BITS-1:0] k;
   } asmc_step_type;

   // query start info, already masked to the active alphabet
   typedef struct packed {
      logic                start;
      logic                empty;
      logic [SET_BITS-1:0] left;
      logic [SET_BITS-1:0] right;
   } asmc_start_type;

   function automatic logic [IDX_BITS-1:0] lowest_index(input logic [SET_BITS-1:0] m);
      logic [IDX_BITS-1:0] idx;
      idx = '0;
      for (int i = SET_BITS - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = IDX_BITS'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic is_single(input logic [SET_BITS-1:0] m);
      return (m != '0) && ((m & (m - SET_BITS'(1))) == '0);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ambiguous_state_median_cost_top.sv =====
// ambiguous_state_median_cost_top: top level of the median state set cost block
// instantiates asmc_seq and asmc_datapath, depends on asmc_pkg
`timescale 1ns / 1ps
`default_nettype none

// Holds a MAX_ALPHABET x MAX_ALPHABET table of transition costs and answers
// queries for the median state set of two ambiguous states. A load beat
// (func 0) writes one table entry and gives no response; rows or columns
// outside the table are dropped. A query beat (func 1) masks both sets to
// the active alphabet n (csr alphabet size, 0 acts as 1, capped at
// MAX_ALPHABET and 8). An empty set answers with empty_error. Two single
// states take one table read. Otherwise the block reads entry (p, k) for
// every state p below n and every candidate k, one read per cycle from the
// single table read port. req_ready is low while a query is in flight.
// The response sits in an output register; a finished query waits there
// for rsp_ready while the next beat can already be taken. The table is
// not cleared at reset: reading an entry never loaded gives garbage.
module ambiguous_state_median_cost_top #(
   parameter int MAX_ALPHABET = 8,
   parameter int COST_BITS    = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_write_en,
   input  wire logic [asmc_pkg::ALPHA_BITS-1:0] csr_write_data,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_func,
   input  wire logic [2:0]                      req_entry_row,
   input  wire logic [2:0]                      req_entry_col,
   input  wire logic [15:0]                     req_entry_cost,
   input  wire logic [asmc_pkg::SET_BITS-1:0]   req_left_set,
   input  wire logic [asmc_pkg::SET_BITS-1:0]   req_right_set,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [asmc_pkg::TOTAL_BITS-1:0]      rsp_total_cost,
   output logic [asmc_pkg::SET_BITS-1:0]        rsp_median_set,
   output logic                                 rsp_empty_error
);
   import asmc_pkg::*;

   localparam int AW = $clog2(MAX_ALPHABET * MAX_ALPHABET);

   // alphabet size register
   logic [ALPHA_BITS-1:0] alphabet_ff, alphabet_in;

   // response output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_BITS-1:0] rsp_total_ff, rsp_total_in;
   logic [SET_BITS-1:0]   rsp_median_ff, rsp_median_in;
   logic                  rsp_error_ff, rsp_error_in;

   logic                  req_accept, query_accept, out_free;
   logic                  idle, deliver;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [COST_BITS-1:0]  wr_data;
   asmc_step_type         step;
   asmc_start_type        start;
   logic [TOTAL_BITS-1:0] res_total;
   logic [SET_BITS-1:0]   res_median;
   logic                  res_error;

   assign req_ready    = idle;
   assign req_accept   = req_valid && req_ready;
   assign query_accept = req_accept && (req_func == FUNC_QUERY);
   // slot is free if empty or being drained this cycle
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // table load, out-of-range rows and columns are dropped
   assign wr_en   = req_accept && (req_func == FUNC_LOAD)
                    && (int'(req_entry_row) < MAX_ALPHABET)
                    && (int'(req_entry_col) < MAX_ALPHABET);
   assign wr_addr = AW'(int'(req_entry_row) * MAX_ALPHABET + int'(req_entry_col));
   assign wr_data = COST_BITS'(req_entry_cost);

   always_comb begin
      alphabet_in = csr_write_en ? csr_write_data : alphabet_ff;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_median_in = rsp_median_ff;
      rsp_error_in  = rsp_error_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (deliver) begin
         rsp_valid_in  = 1'b1;
         rsp_total_in  = res_total;
         rsp_median_in = res_median;
         rsp_error_in  = res_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_ff  <= ALPHA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         alphabet_ff  <= alphabet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_total_ff  <= rsp_total_in;
      rsp_median_ff <= rsp_median_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total_cost  = rsp_total_ff;
   assign rsp_median_set  = rsp_median_ff;
   assign rsp_empty_error = rsp_error_ff;

   asmc_seq #(
      .MAX_ALPHABET (MAX_ALPHABET)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .query_accept (query_accept),
      .left_set     (req_left_set),
      .right_set    (req_right_set),
      .alphabet     (alphabet_ff),
      .out_free     (out_free),
      .idle         (idle),
      .deliver      (deliver),
      .step         (step),
      .start        (start),
      .rd_addr      (rd_addr)
   );

   asmc_datapath #(
      .MAX_ALPHABET (MAX_ALPHABET),
      .COST_BITS    (COST_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .step       (step),
      .start      (start),
      .res_total  (res_total),
      .res_median (res_median),
      .res_error  (res_error)
   );

   // a finished query only lands in a free output slot
   assert property (@(posedge clock) disable iff (reset)
      deliver |-> out_free)
      else $error("response delivered into a full output register");

   // a query beat holds off further request beats
   assert property (@(posedge clock) disable iff (reset)
      query_accept |=> !req_ready)
      else $error("request taken while a query is in flight");

   // an empty set reports zero cost and no median
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_error) |-> (rsp_total_cost == '0 && rsp_median_set == '0))
      else $error("empty set response carries cost or median");

   // a good answer always names at least one median state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_empty_error) |-> (rsp_median_set != '0))
      else $error("response without any median state");

endmodule

`default_nettype wire

// ===== rtl/core/asmc_seq.sv =====
// asmc_seq: query sequencer, walks state p and candidate state k
// and issues one cost table read per cycle
// depends on asmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module asmc_seq #(
   parameter int MAX_ALPHABET = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            query_accept,
   input  wire logic [asmc_pkg::SET_BITS-1:0]   left_set,
   input  wire logic [asmc_pkg::SET_BITS-1:0]   right_set,
   input  wire logic [asmc_pkg::ALPHA_BITS-1:0] alphabet,
   input  wire logic                            out_free,
   output logic                                 idle,
   output logic                                 deliver,
   output asmc_pkg::asmc_step_type              step,
   output asmc_pkg::asmc_start_type             start,
   output logic [$clog2(MAX_ALPHABET*MAX_ALPHABET)-1:0] rd_addr
);
   import asmc_pkg::*;

   localparam int AW   = $clog2(MAX_ALPHABET * MAX_ALPHABET);
   localparam int NMAX = (MAX_ALPHABET < SET_BITS) ? MAX_ALPHABET : SET_BITS;

   asmc_state_type       state_ff, state_in;
   logic [IDX_BITS-1:0]  p_ff, p_in, k_ff, k_in;
   logic [ALPHA_BITS-1:0] n_ff, n_in;
   logic                 direct_ff, direct_in;

   logic [ALPHA_BITS-1:0] n_calc;
   logic [SET_BITS-1:0]   mask, left_m, right_m;
   logic                  p_last, k_last;

   // active state count and masked sets
   always_comb begin
      if (alphabet == '0) begin
         n_calc = ALPHA_BITS'(1);
      end else if (int'(alphabet) > NMAX) begin
         n_calc = ALPHA_BITS'(NMAX);
      end else begin
         n_calc = alphabet;
      end
      mask    = SET_BITS'((9'd1 << n_calc) - 9'd1);
      left_m  = left_set & mask;
      right_m = right_set & mask;
   end

   assign p_last = ({1'b0, p_ff} == (n_ff - ALPHA_BITS'(1)));
   assign k_last = ({1'b0, k_ff} == (n_ff - ALPHA_BITS'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      p_ff      <= p_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
      direct_ff <= direct_in;
   end

   always_comb begin
      state_in  = state_ff;
      p_in      = p_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      direct_in = direct_ff;
      idle      = 1'b0;
      deliver   = 1'b0;

      start.start = query_accept;
      start.empty = (left_m == '0) || (right_m == '0);
      start.left  = left_m;
      start.right = right_m;

      step.valid   = 1'b0;
      step.direct  = direct_ff;
      step.first_p = (p_ff == '0);
      step.last_p  = p_last;
      step.first_k = (k_ff == '0);
      step.p       = p_ff;
      step.k       = k_ff;
      rd_addr      = AW'(int'(p_ff) * MAX_ALPHABET + int'(k_ff));

      unique case (state_ff)
         SEQ_IDLE: begin
            idle = 1'b1;
            if (query_accept) begin
               n_in      = n_calc;
               direct_in = is_single(left_m) && is_single(right_m);
               if (start.empty) begin
                  state_in = SEQ_DONE;
               end else if (is_single(left_m) && is_single(right_m)) begin
                  p_in     = lowest_index(left_m);
                  k_in     = lowest_index(right_m);
                  state_in = SEQ_SCAN;
               end else begin
                  p_in     = '0;
                  k_in     = '0;
                  state_in = SEQ_SCAN;
               end
            end
         end
         SEQ_SCAN: begin
            step.valid = 1'b1;
            if (direct_ff || (p_last && k_last)) begin
               state_in = SEQ_DRAIN_A;
            end else if (p_last) begin
               p_in = '0;
               k_in = k_ff + IDX_BITS'(1);
            end else begin
               p_in = p_ff + IDX_BITS'(1);
            end
         end
         SEQ_DRAIN_A: state_in = SEQ_DRAIN_B;
         SEQ_DRAIN_B: state_in = SEQ_DONE;
         SEQ_DONE: begin
            if (out_free) begin
               deliver  = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/asmc_datapath.sv =====
// asmc_datapath: cost table memory and the shared min / add / compare unit
// depends on asmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module asmc_datapath #(
   parameter int MAX_ALPHABET = 8,
   parameter int COST_BITS    = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        wr_en,
   input  wire logic [$clog2(MAX_ALPHABET*MAX_ALPHABET)-1:0] wr_addr,
   input  wire logic [COST_BITS-1:0]                        wr_data,
   input  wire logic [$clog2(MAX_ALPHABET*MAX_ALPHABET)-1:0] rd_addr,
   input  wire asmc_pkg::asmc_step_type                     step,
   input  wire asmc_pkg::asmc_start_type                    start,
   output logic [asmc_pkg::TOTAL_BITS-1:0]                  res_total,
   output logic [asmc_pkg::SET_BITS-1:0]                    res_median,
   output logic                                             res_error
);
   import asmc_pkg::*;

   localparam int DEPTH = MAX_ALPHABET * MAX_ALPHABET;
   localparam int SW    = COST_BITS + 1;
   localparam int TW    = (SW > TOTAL_BITS) ? SW : TOTAL_BITS;
   localparam logic [SW-1:0] INF = '1;

   logic [COST_BITS-1:0] mem [DEPTH];
   logic [COST_BITS-1:0] rd_ff;
   asmc_step_type        step_ff;

   logic [SW-1:0]        dl_ff, dl_in, dr_ff, dr_in, total_ff, total_in;
   logic [SET_BITS-1:0]  median_ff, median_in, left_ff, left_in, right_ff, right_in;
   logic                 err_ff, err_in;
   logic                 sum_pend_ff, sum_pend_in, sum_first_ff, sum_first_in;
   logic [IDX_BITS-1:0]  sum_k_ff, sum_k_in;

   logic [SW-1:0]        dl_base, dr_base, rd_ext, sum;
   logic [TW-1:0]        total_wide;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         sum_pend_ff <= 1'b0;
      end else begin
         step_ff     <= step;
         sum_pend_ff <= sum_pend_in;
      end
      sum_first_ff <= sum_first_in;
      sum_k_ff     <= sum_k_in;
      dl_ff        <= dl_in;
      dr_ff        <= dr_in;
      total_ff     <= total_in;
      median_ff    <= median_in;
      err_ff       <= err_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
   end

   always_comb begin
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      total_in     = total_ff;
      median_in    = median_ff;
      err_in       = err_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      sum_pend_in  = 1'b0;
      sum_first_in = sum_first_ff;
      sum_k_in     = sum_k_ff;

      rd_ext  = SW'(rd_ff);
      dl_base = step_ff.first_p ? INF : dl_ff;
      dr_base = step_ff.first_p ? INF : dr_ff;
      sum     = SW'(dl_ff + dr_ff);

      // new query
      if (start.start) begin
         left_in  = start.left;
         right_in = start.right;
         err_in   = start.empty;
         if (start.empty) begin
            total_in  = '0;
            median_in = '0;
         end
      end

      // stage 1: direct lookup for two single states, else running minimum over members of each set
      if (step_ff.valid) begin
         if (step_ff.direct) begin
            total_in  = rd_ext;
            median_in = left_ff | right_ff;
         end else begin
            dl_in = (left_ff[step_ff.p] && (rd_ext < dl_base)) ? rd_ext : dl_base;
            dr_in = (right_ff[step_ff.p] && (rd_ext < dr_base)) ? rd_ext : dr_base;
            if (step_ff.last_p) begin
               sum_pend_in  = 1'b1;
               sum_first_in = step_ff.first_k;
               sum_k_in     = step_ff.k;
            end
         end
      end

      // stage 2: combine both distances and keep the best candidates
      if (sum_pend_ff) begin
         if (sum_first_ff || (sum < total_ff)) begin
            total_in  = sum;
            median_in = SET_BITS'(1) << sum_k_ff;
         end else if (sum == total_ff) begin
            median_in = median_ff | (SET_BITS'(1) << sum_k_ff);
         end
      end
   end

   assign total_wide = TW'(total_ff);
   assign res_total  = (total_wide > TW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(total_wide);
   assign res_median = median_ff;
   assign res_error  = err_ff;

endmodule

`default_nettype wire

// ===== sim/tb_ambiguous_state_median_cost_top.sv =====
// tb_ambiguous_state_median_cost_top: self-checking bench for the median state set cost block
// directed rows, then random table loads and queries checked against a local predictor
// depends on asmc_pkg and ambiguous_state_median_cost_top
`timescale 1ns / 1ps

module tb_ambiguous_state_median_cost_top;
   import asmc_pkg::*;

   // wait long enough for a query that scans at most 8 x 8 entries
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_COUNT   = 9;
   localparam int PHASE_BEATS   = 97;

   typedef struct {
      logic                func;
      logic [2:0]          row;
      logic [2:0]          col;
      logic [15:0]         cost;
      logic [SET_BITS-1:0] left;
      logic [SET_BITS-1:0] right;
   } req_beat_t;

   typedef struct {
      logic [TOTAL_BITS-1:0] total;
      logic [SET_BITS-1:0]   median;
      logic                  empty;
   } median_result_t;

   typedef enum {ROW_LOAD, ROW_QUERY, ROW_CSR} row_kind_e;

   // one line of the directed stimulus; want is used only when typed is set
   typedef struct {
      row_kind_e       kind;
      req_beat_t       beat;
      logic [3:0]      alpha;
      bit              typed;
      median_result_t  want;
   } stim_row_t;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  csr_write_en   = 1'b0;
   logic [ALPHA_BITS-1:0] csr_write_data = '0;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic                  req_func       = FUNC_LOAD;
   logic [2:0]            req_entry_row  = '0;
   logic [2:0]            req_entry_col  = '0;
   logic [15:0]           req_entry_cost = '0;
   logic [SET_BITS-1:0]   req_left_set   = '0;
   logic [SET_BITS-1:0]   req_right_set  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [TOTAL_BITS-1:0] rsp_total_cost;
   logic [SET_BITS-1:0]   rsp_median_set;
   logic                  rsp_empty_error;

   // shadow copy of the block state
   logic [15:0]    shadow_costs [8][8];
   logic [3:0]     shadow_alpha;

   median_result_t pending_medians [$];
   stim_row_t      stim_rows [$];

   int  fault_count   = 0;
   int  checked_count = 0;
   int  load_count    = 0;
   int  query_count   = 0;
   int  empty_count   = 0;
   int  cycle_count   = 0;
   int  stall_left    = 0;
   bit  steady_sink   = 1'b0;

   ambiguous_state_median_cost_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_entry_row  (req_entry_row),
      .req_entry_col  (req_entry_col),
      .req_entry_cost (req_entry_cost),
      .req_left_set   (req_left_set),
      .req_right_set  (req_right_set),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_total_cost (rsp_total_cost),
      .rsp_median_set (rsp_median_set),
      .rsp_empty_error(rsp_empty_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // median cost of two state sets under the current alphabet and table
   function automatic median_result_t predict_median(input logic [SET_BITS-1:0] left,
                                                     input logic [SET_BITS-1:0] right);
      median_result_t      r;
      int unsigned         n, lo, ro, dl, dr, sum, best;
      int                  i, k, p;
      logic [SET_BITS-1:0] in_use, lm, rm;
      n = (shadow_alpha == 4'd0) ? 1 : ((shadow_alpha > 4'd8) ? 8 : 32'(shadow_alpha));
      in_use = 8'((16'd1 << n) - 16'd1);
      lm = left & in_use;
      rm = right & in_use;
      r.total  = '0;
      r.median = '0;
      r.empty  = 1'b0;
      lo = 0;
      ro = 0;
      if (lm == '0 || rm == '0) begin
         r.empty = 1'b1;
         return r;
      end
      // two single states: direct lookup, median is both states
      if ($countones(lm) == 1 && $countones(rm) == 1) begin
         for (i = 0; i < SET_BITS; i++) begin
            if (lm[i]) lo = i;
            if (rm[i]) ro = i;
         end
         r.total  = TOTAL_BITS'(shadow_costs[lo][ro]);
         r.median = lm | rm;
         return r;
      end
      best = '1;
      for (k = 0; k < int'(n); k++) begin
         dl = '1;
         dr = '1;
         for (p = 0; p < int'(n); p++) begin
            if (lm[p] && 32'(shadow_costs[p][k]) < dl) dl = 32'(shadow_costs[p][k]);
            if (rm[p] && 32'(shadow_costs[p][k]) < dr) dr = 32'(shadow_costs[p][k]);
         end
         sum = dl + dr;
         if (sum < best) begin
            best     = sum;
            r.median = 8'(1 << k);
         end else if (sum == best) begin
            r.median[k] = 1'b1;
         end
      end
      r.total = (best > 32'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(best);
      return r;
   endfunction

   function automatic void add_row(input row_kind_e kind, input int row, input int col,
                                   input int value, input int left, input int right,
                                   input bit typed, input int total, input int median,
                                   input bit empty);
      stim_row_t s;
      s.kind        = kind;
      s.beat.func   = (kind == ROW_LOAD) ? FUNC_LOAD : FUNC_QUERY;
      s.beat.row    = 3'(row);
      s.beat.col    = 3'(col);
      s.beat.cost   = 16'(value);
      s.beat.left   = 8'(left);
      s.beat.right  = 8'(right);
      s.alpha       = 4'(value);
      s.typed       = typed;
      s.want.total  = TOTAL_BITS'(total);
      s.want.median = 8'(median);
      s.want.empty  = empty;
      stim_rows.push_back(s);
   endfunction

   function automatic logic [15:0] rand_cost();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 16'h0000;
      if (roll < 20) return 16'hFFFF;
      // small costs make ties, so medians with several states
      if (roll < 60) return 16'($urandom_range(0, 7));
      return 16'($urandom);
   endfunction

   function automatic logic [SET_BITS-1:0] rand_set();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 6) return 8'h00;
      if (roll < 30) return 8'(1 << $urandom_range(0, 7));
      if (roll < 40) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic req_beat_t random_beat();
      req_beat_t b;
      b.func  = ($urandom_range(0, 99) < 30) ? FUNC_LOAD : FUNC_QUERY;
      b.row   = 3'($urandom_range(0, 7));
      b.col   = 3'($urandom_range(0, 7));
      b.cost  = rand_cost();
      b.left  = rand_set();
      b.right = rand_set();
      return b;
   endfunction

   // mostly back to back or short gaps, now and then a long one; none in steady mode
   function automatic int pick_gap(input bit steady);
      int unsigned roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // present one beat, hold it until taken, then book its table write or expected response
   task automatic send_beat(input req_beat_t b, input bit typed, input median_result_t want);
      median_result_t pred;
      req_valid      <= 1'b1;
      req_func       <= b.func;
      req_entry_row  <= b.row;
      req_entry_col  <= b.col;
      req_entry_cost <= b.cost;
      req_left_set   <= b.left;
      req_right_set  <= b.right;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      if (b.func == FUNC_LOAD) begin
         shadow_costs[b.row][b.col] = b.cost;
         load_count++;
      end else begin
         pred = predict_median(b.left, b.right);
         pending_medians.push_back(typed ? want : pred);
         query_count++;
         if (pred.empty) empty_count++;
      end
   endtask

   task automatic pause_sender(input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the request side off until every pending response is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_medians.size() != 0);
   endtask

   // alphabet size changes only while the block sits idle
   task automatic write_alphabet(input logic [3:0] alpha);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= alpha;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      shadow_alpha = alpha;
   endtask

   // response side: check each beat against the oldest expectation, then pick next ready
   always @(posedge clock) begin
      median_result_t want;
      int unsigned    roll;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (pending_medians.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("response beat with nothing pending: cost %0d median %02h empty %0b",
                           rsp_total_cost, rsp_median_set, rsp_empty_error);
            end else begin
               want = pending_medians.pop_front();
               checked_count++;
               if (rsp_total_cost !== want.total || rsp_median_set !== want.median ||
                   rsp_empty_error !== want.empty) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("mismatch on response %0d: got cost %0d median %02h empty %0b, %s %0d median %02h empty %0b",
                              checked_count, rsp_total_cost, rsp_median_set, rsp_empty_error,
                              "wanted cost", want.total, want.median, want.empty);
               end
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady_sink) begin
               roll = $urandom_range(0, 99);
               if (roll < 4) stall_left = $urandom_range(10, 60);
               else if (roll < 20) stall_left = $urandom_range(1, 3);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_medians.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      median_result_t no_want;
      req_beat_t      b;
      stim_row_t      s;
      bit             steady;
      int             alpha_plan [PHASE_COUNT];
      int             e, ph, j;

      no_want.total  = '0;
      no_want.median = '0;
      no_want.empty  = 1'b0;
      shadow_alpha   = ALPHA_RESET;

      // directed rows: kind, row, col, cost or alphabet, left, right, typed, cost, median, error
      // alphabet 5 after reset
      add_row(ROW_LOAD,  0, 1, 65535, 0, 0, 0, 0, 0, 0);
      add_row(ROW_LOAD,  1, 0, 0,     0, 0, 0, 0, 0, 0);
      add_row(ROW_LOAD,  0, 0, 'h1234, 0, 0, 0, 0, 0, 0);
      add_row(ROW_QUERY, 0, 0, 0, 'h01, 'h02, 1, 65535, 'h03, 0);
      add_row(ROW_QUERY, 0, 0, 0, 'h02, 'h01, 1, 0,     'h03, 0);
      add_row(ROW_QUERY, 0, 0, 0, 'h01, 'h01, 1, 'h1234, 'h01, 0);
      // empty sets on either side
      add_row(ROW_QUERY, 0, 0, 0, 'h00, 'h02, 1, 0, 0, 1);
      add_row(ROW_QUERY, 0, 0, 0, 'h01, 'h00, 1, 0, 0, 1);
      // set bits above the alphabet are dropped, so these become empty or single
      add_row(ROW_QUERY, 0, 0, 0, 'hE0, 'h01, 1, 0, 0, 1);
      add_row(ROW_QUERY, 0, 0, 0, 'h21, 'h22, 1, 65535, 'h03, 0);
      // two states, all costs at the top: largest possible sum
      add_row(ROW_CSR,   0, 0, 2, 0, 0, 0, 0, 0, 0);
      add_row(ROW_LOAD,  1, 1, 65535, 0, 0, 0, 0, 0, 0);
      add_row(ROW_LOAD,  0, 0, 65535, 0, 0, 0, 0, 0, 0);
      add_row(ROW_LOAD,  1, 0, 65535, 0, 0, 0, 0, 0, 0);
      add_row(ROW_QUERY, 0, 0, 0, 'h03, 'h03, 1, 131070, 'h03, 0);
      add_row(ROW_LOAD,  1, 0, 7, 0, 0, 0, 0, 0, 0);
      add_row(ROW_QUERY, 0, 0, 0, 'h03, 'h01, 0, 0, 0, 0);
      add_row(ROW_QUERY, 0, 0, 0, 'hFE, 'h03, 0, 0, 0, 0);
      // alphabet size zero behaves as one
      add_row(ROW_CSR,   0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ROW_QUERY, 0, 0, 0, 'h01, 'hFF, 1, 65535, 'h01, 0);
      add_row(ROW_QUERY, 0, 0, 0, 'hFE, 'h01, 1, 0, 0, 1);
      // oversized alphabet saturates at eight states
      add_row(ROW_CSR,   0, 0, 15, 0, 0, 0, 0, 0, 0);
      add_row(ROW_QUERY, 0, 0, 0, 'h00, 'hFF, 1, 0, 0, 1);
      add_row(ROW_QUERY, 0, 0, 0, 'h80, 'h00, 1, 0, 0, 1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         s = stim_rows[i];
         if (s.kind == ROW_CSR) begin
            write_alphabet(s.alpha);
         end else begin
            send_beat(s.beat, s.typed, s.want);
            pause_sender(pick_gap(1'b0));
         end
      end

      // load every entry first so no random query reads an unwritten one
      for (e = 0; e < 64; e++) begin
         b      = random_beat();
         b.func = FUNC_LOAD;
         b.row  = 3'(e / 8);
         b.col  = 3'(e % 8);
         send_beat(b, 1'b0, no_want);
         pause_sender(pick_gap(1'b0));
      end

      // alphabet sizes per phase: extremes first, then a few random ones
      alpha_plan = '{8, 1, 0, 15, 2, 7, 0, 0, 0};
      for (ph = 6; ph < PHASE_COUNT; ph++) alpha_plan[ph] = $urandom_range(0, 15);

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         write_alphabet(4'(alpha_plan[ph]));
         steady      = ($urandom_range(0, 3) == 0);
         steady_sink = ($urandom_range(0, 3) == 0);
         for (j = 0; j < PHASE_BEATS; j++) begin
            send_beat(random_beat(), 1'b0, no_want);
            // once in the run, let the pipeline empty out completely
            if (ph == 3 && j == PHASE_BEATS / 2) drain_results();
            else pause_sender(pick_gap(steady));
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d table loads and %0d queries (%0d with an empty set), %0d responses checked",
               load_count, query_count, empty_count, checked_count);
      $display("alphabet sizes 0, 1, 2, 5, 7, 8, 15 plus random, with idle and stall gaps");
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d faults", fault_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
